// File: hdl/frenet_to_cartesian_interp_macros.svh
// Assertion macros used by the checker file of the Frenet converter
`ifndef FRENET_TO_CARTESIAN_INTERP_MACROS_SVH
`define FRENET_TO_CARTESIAN_INTERP_MACROS_SVH

// Same-cycle implication, skipped while reset is low
`define F2C_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("f2c assertion failed");

// Next-cycle implication, skipped while reset is low
`define F2C_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("f2c assertion failed");

`endif

// File: hdl/f2c_pkg.sv
// Shared types, constants and tables of the Frenet-to-Cartesian converter
package f2c_pkg;

    localparam int MAX_WAYPOINTS_DEF = 256;
    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int FRAC_BITS_DEF     = 10;

    localparam int CNT_W      = 9;
    localparam int LEN_W      = 31;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;

    localparam logic [CNT_W-1:0] WAYPOINT_COUNT_RST = 9'd256;
    localparam logic [LEN_W-1:0] TRACK_LENGTH_RST   = 31'd7112247;

    // CORDIC gain compensation, Q30
    localparam logic [31:0] GAIN_INV = 32'd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAYPOINT_COUNT = 1'b0,
        CFG_TRACK_LENGTH   = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_CONVERT = 1'b1
    } t_op;

    // Direction jobs run through the shared CORDIC unit
    typedef enum logic [1:0] {
        JOB_HEAD  = 2'd0,
        JOB_PREV  = 2'd1,
        JOB_NEXT  = 2'd2,
        JOB_BLEND = 2'd3
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_SRCH_ADDR,
        ST_SRCH_CMP,
        ST_FETCH,
        ST_WDIV,
        ST_VEC_INIT,
        ST_VEC_IT,
        ST_ROT_INIT,
        ST_ROT_IT,
        ST_MUL,
        ST_OUT
    } t_state;

    // Classified item handed from front to back
    typedef struct packed {
        logic                is_load;
        logic                slot_ok;
        logic [7:0]          idx;
        logic [30:0]         wp_s;
        logic signed [31:0]  wp_x;
        logic signed [31:0]  wp_y;
        logic [30:0]         qs;
        logic signed [16:0]  qd;
    } t_cmd;

    // atan(2^-i) in binary angle units (2^32 per turn)
    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/f2c_in_if.sv
// Input channel: waypoint loads and Frenet queries
interface f2c_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [7:0]         wp_index;
    logic [30:0]        wp_s;
    logic signed [31:0] wp_x;
    logic signed [31:0] wp_y;
    logic [30:0]        query_s;
    logic signed [16:0] query_d;

    modport source (output valid, operation, wp_index, wp_s, wp_x, wp_y, query_s, query_d,
                    input ready);
    modport sink   (input valid, operation, wp_index, wp_s, wp_x, wp_y, query_s, query_d,
                    output ready);
endinterface

// File: hdl/f2c_out_if.sv
// Output channel: converted Cartesian points
interface f2c_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;

    modport source (output valid, out_x, out_y, input ready);
    modport sink   (input valid, out_x, out_y, output ready);
endinterface

// File: hdl/f2c_ram.sv
// Generic single-write, single-read RAM with registered read data
module f2c_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/f2c_front.sv
// Front end: accepts items, classifies them and queues them for the back end
module f2c_front #(
    parameter int MAX_WAYPOINTS = f2c_pkg::MAX_WAYPOINTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    f2c_in_if.sink        i_in,
    output f2c_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);
    import f2c_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    t_cmd       cmd_in;

    // Classify: load or convert, and whether the slot exists
    always_comb begin
        cmd_in.is_load = (i_in.operation == OP_LOAD);
        cmd_in.slot_ok = ({24'd0, i_in.wp_index} < 32'(MAX_WAYPOINTS));
        cmd_in.idx     = i_in.wp_index;
        cmd_in.wp_s    = i_in.wp_s;
        cmd_in.wp_x    = i_in.wp_x;
        cmd_in.wp_y    = i_in.wp_y;
        cmd_in.qs      = i_in.query_s;
        cmd_in.qd      = i_in.query_d;
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd       = r_q[r_rd];
    assign o_cmd_valid = (r_cnt != 2'd0);

    // Two-entry queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
    end
endmodule

// File: hdl/f2c_back.sv
// Back end: waypoint table, segment search, CORDIC headings and point offset
module f2c_back #(
    parameter int MAX_WAYPOINTS = f2c_pkg::MAX_WAYPOINTS_DEF,
    parameter int CORDIC_STEPS  = f2c_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS     = f2c_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  f2c_pkg::t_cmd                  i_cmd,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_pop,
    input  logic                           i_cfg_we,
    input  logic [f2c_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [f2c_pkg::CFG_DATA_W-1:0] i_cfg_data,
    f2c_out_if.source                      o_out
);
    import f2c_pkg::*;

    localparam int IW = $clog2(MAX_WAYPOINTS);
    localparam int NW = IW + 1;
    localparam int CW = FRAC_BITS + 36;
    localparam logic [FRAC_BITS:0] FULL = {1'b1, {FRAC_BITS{1'b0}}};

    localparam logic [4:0] MOD_LAST    = 5'(LEN_W - 1);
    localparam logic [4:0] FETCH_LAST  = 5'd4;
    localparam logic [4:0] WDIV_LAST   = 5'(FRAC_BITS);
    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic [4:0] MUL_BLEND_LAST = 5'd11;
    localparam logic [4:0] MUL_OFS_FIRST  = 5'd12;
    localparam logic [4:0] MUL_LAST       = 5'd15;

    // Product steps of the shared multiplier
    localparam logic [2:0] MS_HEAD_X  = 3'd0;
    localparam logic [2:0] MS_HEAD_Y  = 3'd1;
    localparam logic [2:0] MS_BC_PREV = 3'd2;
    localparam logic [2:0] MS_BC_NEXT = 3'd3;
    localparam logic [2:0] MS_BS_PREV = 3'd4;
    localparam logic [2:0] MS_BS_NEXT = 3'd5;
    localparam logic [2:0] MS_OFS_X   = 3'd6;
    localparam logic [2:0] MS_OFS_Y   = 3'd7;

    t_state n_state;
    t_state r_state;

    // Configuration
    logic [CNT_W-1:0] r_wcnt;
    logic [LEN_W-1:0] r_tlen;

    // Query and search
    logic [30:0]        r_qs;
    logic [30:0]        r_s;
    logic signed [16:0] r_d;
    logic [4:0]         r_cnt;
    logic [NW-1:0]      r_n;
    logic [NW-1:0]      r_lo;
    logic [NW-1:0]      r_hi;
    logic [IW-1:0]      r_wp [4];

    // Fetched waypoints: slot 0 wp1, 1 wp2, 2 wp0, 3 wp3
    logic signed [31:0] r_wx [4];
    logic signed [31:0] r_wy [4];
    logic [30:0]        r_s1;
    logic [30:0]        r_s2;
    logic signed [31:0] r_seg;
    logic signed [31:0] r_len;
    logic [FRAC_BITS:0] r_w;
    logic [31:0]        r_wrem;

    // CORDIC
    t_job               r_job;
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic signed [33:0] r_cz;
    logic [31:0]        r_ang;
    logic               r_flip;
    logic signed [31:0] r_hc, r_hs, r_c1, r_s1u, r_c2, r_s2u, r_pc, r_ps;

    // Products and sums
    logic signed [65:0]   r_prod;
    logic signed [35:0]   r_px;
    logic signed [35:0]   r_py;
    logic signed [CW-1:0] r_bc;
    logic signed [CW-1:0] r_bs;

    // Output register
    logic               r_ovalid;
    logic signed [31:0] r_ox;
    logic signed [31:0] r_oy;

    // RAM ports
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    logic [30:0]   rd_s;
    logic [31:0]   rd_x;
    logic [31:0]   rd_y;

    logic [NW-1:0] n_eff;
    logic [NW:0]   mid_sum;
    logic [NW-1:0] mid;
    logic [NW-1:0] wp1_n, wp2_n, wp3_n, wp0_n;
    logic [31:0]   mod_t;
    logic [30:0]   mod_next;
    logic [32:0]   wdiv_t;
    logic          wdiv_ge;
    logic          seg_pos, len_pos, seg_ge_len, wdiv_done;
    logic [30:0]   end_s;
    logic signed [CW-1:0] vsx, vsy;
    logic          vec_zero;
    logic signed [CW-1:0] vx_sh, vy_sh;
    logic [31:0]   at;
    logic signed [CW-1:0] vec_nx, vec_ny, rot_nx, rot_ny;
    logic [31:0]   vec_na;
    logic signed [33:0] rot_nz;
    logic [31:0]   rot_t, rot_a;
    logic signed [31:0] rot_c, rot_s;
    logic [2:0]    mstep;
    logic signed [33:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [65:0] prod_rnd_sum;
    logic signed [35:0] prod_rnd;
    logic          out_load;

    // Waypoint table
    f2c_ram #(.WIDTH(31), .DEPTH(MAX_WAYPOINTS)) u_ram_s (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(i_cmd.wp_s),
        .i_raddr(ram_raddr), .o_rdata(rd_s)
    );
    f2c_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_x (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(i_cmd.wp_x),
        .i_raddr(ram_raddr), .o_rdata(rd_x)
    );
    f2c_ram #(.WIDTH(32), .DEPTH(MAX_WAYPOINTS)) u_ram_y (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(i_cmd.wp_y),
        .i_raddr(ram_raddr), .o_rdata(rd_y)
    );

    // Effective waypoint count, clamped to [1, MAX_WAYPOINTS]
    always_comb begin
        if (r_wcnt == '0) begin
            n_eff = NW'(1);
        end else if ({23'd0, r_wcnt} > 32'(MAX_WAYPOINTS)) begin
            n_eff = NW'(MAX_WAYPOINTS);
        end else begin
            n_eff = NW'(r_wcnt);
        end
    end

    // Binary search midpoint and neighbor indexes
    always_comb begin
        mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
        mid     = mid_sum[NW:1];
        wp1_n   = (r_lo == '0) ? '0 : r_lo - NW'(1);
        wp2_n   = (wp1_n + NW'(1) == r_n) ? '0 : wp1_n + NW'(1);
        wp3_n   = (wp2_n + NW'(1) == r_n) ? '0 : wp2_n + NW'(1);
        wp0_n   = (wp1_n == '0) ? r_n - NW'(1) : wp1_n - NW'(1);
    end

    // One restoring step of s modulo track length
    always_comb begin
        mod_t    = {r_s, r_qs[30]};
        mod_next = (mod_t >= {1'b0, r_tlen}) ? 31'(mod_t - {1'b0, r_tlen}) : mod_t[30:0];
    end

    // Blend weight division
    always_comb begin
        end_s      = (r_wp[1] == '0) ? r_tlen : r_s2;
        seg_pos    = !r_seg[31] && (r_seg != '0);
        len_pos    = !r_len[31] && (r_len != '0);
        seg_ge_len = (r_seg >= r_len);
        wdiv_t     = {r_wrem, 1'b0};
        wdiv_ge    = (wdiv_t >= {1'b0, r_len});
        if (r_cnt == '0) begin
            wdiv_done = !(seg_pos && len_pos && !seg_ge_len);
        end else begin
            wdiv_done = (r_cnt == WDIV_LAST);
        end
    end

    // Vector sources per job
    always_comb begin
        unique case (r_job)
            JOB_HEAD: begin
                vsx = CW'(33'(r_wx[1]) - 33'(r_wx[0]));
                vsy = CW'(33'(r_wy[1]) - 33'(r_wy[0]));
            end
            JOB_PREV: begin
                vsx = CW'(33'(r_wx[1]) - 33'(r_wx[2]));
                vsy = CW'(33'(r_wy[1]) - 33'(r_wy[2]));
            end
            JOB_NEXT: begin
                vsx = CW'(33'(r_wx[3]) - 33'(r_wx[0]));
                vsy = CW'(33'(r_wy[3]) - 33'(r_wy[0]));
            end
            default: begin
                vsx = r_bc;
                vsy = r_bs;
            end
        endcase
        vec_zero = (vsx == '0) && (vsy == '0);
    end

    // CORDIC micro-rotation, vectoring and rotation modes
    always_comb begin
        vx_sh = r_cx >>> r_cnt;
        vy_sh = r_cy >>> r_cnt;
        at    = atan_turn(r_cnt);
        if (!r_cy[CW-1] && (r_cy != '0)) begin
            vec_nx = r_cx + vy_sh;
            vec_ny = r_cy - vx_sh;
            vec_na = r_ang + at;
        end else begin
            vec_nx = r_cx - vy_sh;
            vec_ny = r_cy + vx_sh;
            vec_na = r_ang - at;
        end
        if (!r_cz[33]) begin
            rot_nx = r_cx - vy_sh;
            rot_ny = r_cy + vx_sh;
            rot_nz = r_cz - $signed({2'b00, at});
        end else begin
            rot_nx = r_cx + vy_sh;
            rot_ny = r_cy - vx_sh;
            rot_nz = r_cz + $signed({2'b00, at});
        end
        rot_c = r_flip ? 32'(-rot_nx) : 32'(rot_nx);
        rot_s = r_flip ? 32'(-rot_ny) : 32'(rot_ny);
        rot_t = r_ang + 32'h4000_0000;
        rot_a = rot_t[31] ? (r_ang ^ 32'h8000_0000) : r_ang;
    end

    // Shared multiplier operands
    always_comb begin
        mstep = r_cnt[3:1];
        unique case (mstep)
            MS_HEAD_X:  begin mul_a = 34'(r_seg); mul_b = r_hc;  end
            MS_HEAD_Y:  begin mul_a = 34'(r_seg); mul_b = r_hs;  end
            MS_BC_PREV: begin mul_a = $signed({{(33-FRAC_BITS){1'b0}}, FULL - r_w}); mul_b = r_c1; end
            MS_BC_NEXT: begin mul_a = $signed({{(33-FRAC_BITS){1'b0}}, r_w}); mul_b = r_c2; end
            MS_BS_PREV: begin mul_a = $signed({{(33-FRAC_BITS){1'b0}}, FULL - r_w}); mul_b = r_s1u; end
            MS_BS_NEXT: begin mul_a = $signed({{(33-FRAC_BITS){1'b0}}, r_w}); mul_b = r_s2u; end
            MS_OFS_X:   begin mul_a = 34'(r_d);   mul_b = r_ps;  end
            default:    begin mul_a = 34'(r_d);   mul_b = r_pc;  end
        endcase
        prod_rnd_sum = r_prod + 66'sd536870912;
        prod_rnd     = 36'(prod_rnd_sum >>> 30);
    end

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && !i_cmd.is_load) begin
                    n_state = (r_tlen != '0) ? ST_MOD : ST_SRCH_ADDR;
                end
            end
            ST_MOD:       if (r_cnt == MOD_LAST) n_state = ST_SRCH_ADDR;
            ST_SRCH_ADDR: n_state = (r_lo < r_hi) ? ST_SRCH_CMP : ST_FETCH;
            ST_SRCH_CMP:  n_state = ST_SRCH_ADDR;
            ST_FETCH:     if (r_cnt == FETCH_LAST) n_state = ST_WDIV;
            ST_WDIV:      if (wdiv_done) n_state = ST_VEC_INIT;
            ST_VEC_INIT:  n_state = vec_zero ? ST_ROT_INIT : ST_VEC_IT;
            ST_VEC_IT:    if (r_cnt == CORDIC_LAST) n_state = ST_ROT_INIT;
            ST_ROT_INIT:  n_state = ST_ROT_IT;
            ST_ROT_IT: begin
                if (r_cnt == CORDIC_LAST) begin
                    n_state = (r_job == JOB_HEAD || r_job == JOB_PREV) ? ST_VEC_INIT : ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_cnt == MUL_BLEND_LAST) n_state = ST_VEC_INIT;
                else if (r_cnt == MUL_LAST)  n_state = ST_OUT;
            end
            ST_OUT:       if (out_load) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
        ram_we    = o_cmd_pop && i_cmd.is_load && i_cmd.slot_ok;
        ram_waddr = IW'(i_cmd.idx);
        out_load  = (r_state == ST_OUT) && (!r_ovalid || o_out.ready);
        unique case (r_state)
            ST_SRCH_ADDR: ram_raddr = mid[IW-1:0];
            ST_FETCH:     ram_raddr = r_wp[r_cnt[1:0]];
            default:      ram_raddr = '0;
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_wcnt   <= WAYPOINT_COUNT_RST;
            r_tlen   <= TRACK_LENGTH_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_WAYPOINT_COUNT) begin
                    r_wcnt <= i_cfg_data[CNT_W-1:0];
                end else if (i_cfg_idx == CFG_TRACK_LENGTH) begin
                    r_tlen <= i_cfg_data[LEN_W-1:0];
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && !i_cmd.is_load) begin
                    r_qs  <= i_cmd.qs;
                    r_d   <= i_cmd.qd;
                    r_s   <= (r_tlen == '0) ? i_cmd.qs : '0;
                    r_cnt <= '0;
                    r_n   <= n_eff;
                    r_lo  <= '0;
                    r_hi  <= n_eff;
                    r_job <= JOB_HEAD;
                end
            end
            ST_MOD: begin
                r_qs  <= {r_qs[29:0], 1'b0};
                r_s   <= mod_next;
                r_cnt <= r_cnt + 5'd1;
            end
            ST_SRCH_ADDR: begin
                if (!(r_lo < r_hi)) begin
                    r_wp[0] <= wp1_n[IW-1:0];
                    r_wp[1] <= wp2_n[IW-1:0];
                    r_wp[2] <= wp0_n[IW-1:0];
                    r_wp[3] <= wp3_n[IW-1:0];
                    r_cnt   <= '0;
                end
            end
            ST_SRCH_CMP: begin
                if (rd_s < r_s) begin
                    r_lo <= mid + NW'(1);
                end else begin
                    r_hi <= mid;
                end
            end
            ST_FETCH: begin
                if (r_cnt != '0) begin
                    r_wx[r_cnt[1:0] - 2'd1] <= rd_x;
                    r_wy[r_cnt[1:0] - 2'd1] <= rd_y;
                    if (r_cnt == 5'd1) r_s1 <= rd_s;
                    if (r_cnt == 5'd2) r_s2 <= rd_s;
                end
                if (r_cnt == FETCH_LAST) begin
                    r_seg <= $signed({1'b0, r_s}) - $signed({1'b0, r_s1});
                    r_len <= $signed({1'b0, end_s}) - $signed({1'b0, r_s1});
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            ST_WDIV: begin
                if (r_cnt == '0) begin
                    r_w    <= (seg_pos && len_pos && seg_ge_len) ? FULL : '0;
                    r_wrem <= r_seg;
                end else begin
                    r_wrem <= wdiv_ge ? 32'(wdiv_t - {1'b0, r_len}) : wdiv_t[31:0];
                    r_w    <= {r_w[FRAC_BITS-1:0], wdiv_ge};
                end
                r_cnt <= wdiv_done ? '0 : r_cnt + 5'd1;
            end
            ST_VEC_INIT: begin
                r_cx  <= vsx[CW-1] ? -vsx : vsx;
                r_cy  <= vsx[CW-1] ? -vsy : vsy;
                r_ang <= (!vec_zero && vsx[CW-1]) ? 32'h8000_0000 : 32'h0;
                r_cnt <= '0;
            end
            ST_VEC_IT: begin
                r_cx  <= vec_nx;
                r_cy  <= vec_ny;
                r_ang <= vec_na;
                r_cnt <= (r_cnt == CORDIC_LAST) ? '0 : r_cnt + 5'd1;
            end
            ST_ROT_INIT: begin
                r_cx   <= CW'(GAIN_INV);
                r_cy   <= '0;
                r_cz   <= 34'($signed(rot_a));
                r_flip <= rot_t[31];
                r_cnt  <= '0;
            end
            ST_ROT_IT: begin
                r_cx <= rot_nx;
                r_cy <= rot_ny;
                r_cz <= rot_nz;
                if (r_cnt == CORDIC_LAST) begin
                    unique case (r_job)
                        JOB_HEAD:  begin r_hc <= rot_c; r_hs  <= rot_s; end
                        JOB_PREV:  begin r_c1 <= rot_c; r_s1u <= rot_s; end
                        JOB_NEXT:  begin r_c2 <= rot_c; r_s2u <= rot_s; end
                        default:   begin r_pc <= rot_c; r_ps  <= rot_s; end
                    endcase
                    r_cnt <= (r_job == JOB_BLEND) ? MUL_OFS_FIRST : '0;
                    if (r_job != JOB_BLEND) begin
                        r_job <= t_job'(r_job + 2'd1);
                    end
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            ST_MUL: begin
                if (!r_cnt[0]) begin
                    r_prod <= mul_a * mul_b;
                end else begin
                    unique case (mstep)
                        MS_HEAD_X:  r_px <= 36'(r_wx[0]) + prod_rnd;
                        MS_HEAD_Y:  r_py <= 36'(r_wy[0]) + prod_rnd;
                        MS_BC_PREV: r_bc <= CW'(r_prod);
                        MS_BC_NEXT: r_bc <= r_bc + CW'(r_prod);
                        MS_BS_PREV: r_bs <= CW'(r_prod);
                        MS_BS_NEXT: r_bs <= r_bs + CW'(r_prod);
                        MS_OFS_X:   r_px <= r_px + prod_rnd;
                        default:    r_py <= r_py - prod_rnd;
                    endcase
                end
                r_cnt <= (r_cnt == MUL_BLEND_LAST) ? '0 : r_cnt + 5'd1;
            end
            ST_OUT: begin
                if (out_load) begin
                    r_ox <= sat32(r_px);
                    r_oy <= sat32(r_py);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid = r_ovalid;
    assign o_out.out_x = r_ox;
    assign o_out.out_y = r_oy;
endmodule

// File: hdl/frenet_to_cartesian_interp.sv
// Frenet-to-Cartesian converter: top level
//
// Input channel i_in carries load items (operation 0: write wp_s/wp_x/wp_y
// into table slot wp_index, no result) and convert items (operation 1: turn
// query_s/query_d into one Cartesian point on o_out). Items are transferred
// on valid and ready both high and are handled strictly in order.
// The configuration port writes waypoint_count (index 0) or track_length
// (index 1); the user must write it only while the block is idle, as the
// block leaves this check to the user. A two-entry queue decouples
// acceptance from the sequential back end, which works on one item at a
// time. A convert passes through the modulo step (when track_length is
// nonzero), the binary search, the waypoint fetch, the blend weight
// division, the shared CORDIC and the shared multiplier before the output;
// the single CORDIC unit dominates. The result sits in an output register,
// so a stalled receiver holds the back end only when the next result is ready.
// Reset clears the queue and the output valid and returns both configuration
// registers to their defaults; table contents are undefined until loaded.
module frenet_to_cartesian_interp #(
    parameter int MAX_WAYPOINTS = f2c_pkg::MAX_WAYPOINTS_DEF,
    parameter int CORDIC_STEPS  = f2c_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS     = f2c_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    f2c_in_if.sink                         i_in,
    f2c_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [f2c_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [f2c_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import f2c_pkg::*;

    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    f2c_front #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    f2c_back #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS),
        .CORDIC_STEPS  (CORDIC_STEPS),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out       (o_out)
    );
endmodule

// File: hdl/f2c_checker.sv
// Port-level checker for the Frenet converter and its bind
`include "frenet_to_cartesian_interp_macros.svh"

module f2c_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_op,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_x,
    input logic [31:0] out_y
);
    import f2c_pkg::*;

    logic [2:0] r_pend;
    logic       conv_in;
    logic       out_xfer;

    assign conv_in  = in_valid && in_ready && (in_op == OP_CONVERT);
    assign out_xfer = out_valid && out_ready;

    // Convert items accepted but not yet delivered
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            r_pend <= 3'd0;
        end else begin
            r_pend <= r_pend + {2'd0, conv_in} - {2'd0, out_xfer};
        end
    end

    `F2C_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `F2C_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_x) && $stable(out_y))
    `F2C_ASSERT_NEXT(a_rst_clears, clk, 1'b1, !rst_n, !out_valid)
    `F2C_ASSERT_SAME(a_no_orphan, clk, rst_n, out_valid, r_pend != 3'd0)
endmodule

bind frenet_to_cartesian_interp f2c_checker u_f2c_checker (
    .clk       (i_clk),
    .rst_n     (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .in_op     (i_in.operation),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_x     (o_out.out_x),
    .out_y     (o_out.out_y)
);

// File: dv/tb_frenet_to_cartesian_interp.sv
// Testbench for the Frenet-to-Cartesian converter: waypoint loads, random queries, scoreboard
`timescale 1ns / 1ps

import f2c_pkg::*;

// Tracks the waypoint table and configuration, and predicts every converted point
class frenet_point_board;
    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
    } t_point;

    int unsigned atan_tab[16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };
    longint     wp_s_tab[256];
    longint     wp_x_tab[256];
    longint     wp_y_tab[256];
    logic [8:0]  wp_count  = WAYPOINT_COUNT_RST;
    logic [30:0] track_len = TRACK_LENGTH_RST;
    t_point     points_due[$];
    int         errors;

    function void set_reg(t_cfg_idx idx, logic [30:0] val);
        if (idx == CFG_WAYPOINT_COUNT) wp_count = val[8:0];
        else track_len = val;
    endfunction

    function int pending();
        return points_due.size();
    endfunction

    // binary angle of a vector, vectoring CORDIC
    function logic [31:0] bearing(longint vx, longint vy);
        logic [31:0] a;
        longint dx, dy;
        a = 0;
        if (vx == 0 && vy == 0) return 0;
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            a = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy > 0) begin
                vx += dx; vy -= dy; a += atan_tab[i];
            end else begin
                vx -= dx; vy += dy; a -= atan_tab[i];
            end
        end
        return a;
    endfunction

    // Q30 unit vector of a binary angle, rotation CORDIC
    function void unit_vec(logic [31:0] a, output longint c, output longint s);
        bit     flip;
        longint ux, uy, z, dx, dy;
        logic [31:0] t;
        flip = 0;
        ux = GAIN_INV;
        uy = 0;
        t = a + 32'h4000_0000;
        if (t[31]) begin
            flip = 1;
            a += 32'h8000_0000;
        end
        z = longint'($signed(a));
        for (int i = 0; i < 16; i++) begin
            dx = uy >>> i;
            dy = ux >>> i;
            if (z >= 0) begin
                ux -= dx; uy += dy; z -= atan_tab[i];
            end else begin
                ux += dx; uy -= dy; z += atan_tab[i];
            end
        end
        c = flip ? -ux : ux;
        s = flip ? -uy : uy;
    endfunction

    function void seg_dir(int from, int to, output longint c, output longint s);
        unit_vec(bearing(wp_x_tab[to] - wp_x_tab[from], wp_y_tab[to] - wp_y_tab[from]), c, s);
    endfunction

    function longint scale_q30(longint len, longint u);
        return (len * u + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // Note one accepted input transfer
    function void note_item(t_op op, logic [7:0] idx, logic [30:0] ws, logic signed [31:0] wx,
                            logic signed [31:0] wy, logic [30:0] qs, logic signed [16:0] qd);
        int     n, lo, hi, mid, w0, w1, w2, w3;
        longint s, seg_s, end_s, len, w, hc, hs, c1, s1, c2, s2, bc, bs, pc, ps, d, x, y;
        t_point p;
        if (op == OP_LOAD) begin
            wp_s_tab[idx] = ws;
            wp_x_tab[idx] = wx;
            wp_y_tab[idx] = wy;
            return;
        end
        n = wp_count;
        if (n < 1) n = 1;
        if (n > 256) n = 256;
        s = qs;
        if (track_len != 0) s = s % longint'(track_len);
        d = qd;
        lo = 0;
        hi = n;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (wp_s_tab[mid] < s) lo = mid + 1;
            else hi = mid;
        end
        w1 = (lo == 0) ? 0 : lo - 1;
        w2 = (w1 + 1) % n;
        w3 = (w2 + 1) % n;
        w0 = (w1 == 0) ? n - 1 : w1 - 1;
        seg_s = s - wp_s_tab[w1];
        end_s = (w2 == 0) ? longint'(track_len) : wp_s_tab[w2];
        len = end_s - wp_s_tab[w1];
        w = 0;
        if (seg_s > 0 && len > 0) begin
            w = (seg_s * 1024) / len;
            if (w > 1024) w = 1024;
        end
        seg_dir(w1, w2, hc, hs);
        x = wp_x_tab[w1] + scale_q30(seg_s, hc);
        y = wp_y_tab[w1] + scale_q30(seg_s, hs);
        seg_dir(w0, w2, c1, s1);
        seg_dir(w1, w3, c2, s2);
        bc = (1024 - w) * c1 + w * c2;
        bs = (1024 - w) * s1 + w * s2;
        unit_vec(bearing(bc, bs), pc, ps);
        x += scale_q30(d, ps);
        y -= scale_q30(d, pc);
        p.px = clip32(x);
        p.py = clip32(y);
        points_due = {points_due, p};
    endfunction

    // Compare one output transfer with the oldest prediction
    function void check_point(logic signed [31:0] ox, logic signed [31:0] oy);
        t_point p;
        if (points_due.size() == 0) begin
            $error("unexpected point x=%0d y=%0d", ox, oy);
            errors++;
            return;
        end
        p = points_due[0];
        points_due.delete(0);
        if (ox !== p.px) begin
            $error("out_x expected %0d actual %0d", p.px, ox);
            errors++;
        end
        if (oy !== p.py) begin
            $error("out_y expected %0d actual %0d", p.py, oy);
            errors++;
        end
    endfunction
endclass

module tb_frenet_to_cartesian_interp;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    bit          quiet = 0;
    bit          hold_req = 0;
    frenet_point_board board = new();

    f2c_in_if  in_ch();
    f2c_out_if out_ch();

    frenet_to_cartesian_interp uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    initial begin
        in_ch.valid = 0; in_ch.operation = 0; in_ch.wp_index = 0; in_ch.wp_s = 0;
        in_ch.wp_x = 0; in_ch.wp_y = 0; in_ch.query_s = 0; in_ch.query_d = 0;
        out_ch.ready = 0;
    end

    // Watchdog
    initial begin
        #60_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random ready bursts, one long hold-off on request
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 0;
                out_ch.ready <= 0;
                n = 0;
                while (n < 3000) begin
                    @(posedge i_clk);
                    n++;
                end
            end
            out_ch.ready <= 1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if (!quiet) begin
                out_ch.ready <= 0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
        end
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) board.check_point(out_ch.out_x, out_ch.out_y);
    end

    // One input transfer, with an optional idle burst ahead of it
    task automatic send(t_op op, logic [7:0] idx, logic [30:0] ws, logic [31:0] wx,
                        logic [31:0] wy, logic [30:0] qs, logic [16:0] qd);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_ch.valid     <= 1;
        in_ch.operation <= op;
        in_ch.wp_index  <= idx;
        in_ch.wp_s      <= ws;
        in_ch.wp_x      <= wx;
        in_ch.wp_y      <= wy;
        in_ch.query_s   <= qs;
        in_ch.query_d   <= qd;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_item(op, idx, ws, wx, wy, qs, qd);
    endtask

    task automatic load_wp(int idx, logic [30:0] ws, logic [31:0] wx, logic [31:0] wy);
        send(OP_LOAD, idx[7:0], ws, wx, wy, $urandom(), $urandom());
    endtask

    task automatic query(logic [30:0] qs, logic [16:0] qd);
        send(OP_CONVERT, $urandom(), $urandom(), $urandom(), $urandom(), qs, qd);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // Register write while the block is idle; the enable is low again before the task returns
    task automatic write_reg(t_cfg_idx idx, logic [30:0] val);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 0;
        board.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Load slots 0..cnt-1 as an ordered track spanning span
    task automatic load_track(int cnt, longint span);
        longint step, s, x, y;
        step = span / cnt;
        if (step < 1) step = 1;
        s = $urandom_range(1, 1000);
        x = $signed($urandom_range(0, 2000000)) - 1000000;
        y = $signed($urandom_range(0, 2000000)) - 1000000;
        for (int i = 0; i < cnt; i++) begin
            load_wp(i, s[30:0], x[31:0], y[31:0]);
            s += $urandom_range(1, int'(step));
            if (s > 64'h7FFF_FFFF) s = 64'h7FFF_FFFF;
            // occasional coincident neighbor
            if ($urandom_range(0, 15) != 0) begin
                x += $signed($urandom_range(0, 60000)) - 20000;
                y += $signed($urandom_range(0, 60000)) - 30000;
            end
        end
    endtask

    function automatic logic [30:0] pick_len();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 31'h7FFF_FFFF;
            3: return TRACK_LENGTH_RST;
            default: return $urandom_range(1000, 20000000);
        endcase
    endfunction

    function automatic logic [8:0] pick_count();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return 1;
            2: return 3;
            3: return 256;
            4: return 511;
            5: return $urandom_range(4, 32);
            default: return $urandom_range(3, 256);
        endcase
    endfunction

    initial begin
        logic [30:0] tl;
        logic [8:0]  cnt;
        longint      spread;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Full table, ordered over the default track length
        load_track(256, TRACK_LENGTH_RST);
        // extreme coordinates for saturation
        load_wp(200, board.wp_s_tab[200], 32'h7FFF_FFFF, 32'h8000_0000);

        // Directed queries at the default configuration
        query(0, 0);
        query(31'h7FFF_FFFF, 17'h0FFFF);
        query(TRACK_LENGTH_RST - 1, 17'h10000);
        query(TRACK_LENGTH_RST, 0);
        query(board.wp_s_tab[0], 17'h0FFFF);
        query(board.wp_s_tab[5], 0);
        query(board.wp_s_tab[255] + 1, 17'h10000);
        query(board.wp_s_tab[200] + 3, 17'h0FFFF);
        query(board.wp_s_tab[200] + 7, 17'h10000);
        query(board.wp_s_tab[199] + 9, 17'h0FFFF);
        query(board.wp_s_tab[128] - 1, 17'h1FFFF);
        for (int i = 0; i < 10; i++) query($urandom_range(0, TRACK_LENGTH_RST), $urandom());

        // Random phases, each with its own configuration
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            cnt = (ph == 0) ? 9'd511 : (ph == 1) ? 9'd0 : (ph == 2) ? 9'd3 : pick_count();
            tl  = (ph == 0) ? 31'h7FFF_FFFF : (ph == 1) ? 31'd0 : (ph == 2) ? 31'd1 : pick_len();
            write_reg(CFG_WAYPOINT_COUNT, cnt);
            write_reg(CFG_TRACK_LENGTH, tl);
            if (ph == 3) hold_req = 1;
            if (ph == 9) quiet = 1;
            spread = (tl == 0) ? 64'h7FFF_0000 : longint'(tl);
            // ordered reload keeps the search on a well-formed track
            if (cnt != 0 && cnt <= 40 && $urandom_range(0, 2) != 0) load_track(cnt, spread);
            for (int k = 0; k < 75; k++) begin
                if ($urandom_range(0, 9) == 0)
                    load_wp($urandom_range(0, 255), $urandom(), $urandom(), $urandom());
                else if ($urandom_range(0, 3) == 0)
                    query($urandom(), $urandom());
                else
                    query($urandom_range(0, int'(spread > 64'h7FFF_FFFF ? 64'h7FFF_FFFF
                                                  : spread + spread / 8)), $urandom());
            end
        end

        // Wind down
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (board.errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
